// File: rtl/windowed_moving_average_assert.svh
// Assertion shorthands shared by the windowed_moving_average modules.
// Each one expects clk_i and rst_ni in scope.
`ifndef WINDOWED_MOVING_AVERAGE_ASSERT_SVH
`define WINDOWED_MOVING_AVERAGE_ASSERT_SVH

// Same-cycle implication.
`define WMA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define WMA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/wma_pkg.sv
`timescale 1ns / 1ps

package wma_pkg;

  localparam int unsigned SAMPLE_W = 18;
  localparam int unsigned AVG_W    = 26;
  localparam int unsigned HELD_W   = 11;
  localparam int unsigned WSIZE_W  = 11;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic [WSIZE_W-1:0] WSIZE_RESET = WSIZE_W'(3);

  localparam logic [AVG_W-1:0] AVG_MAX = {1'b0, {(AVG_W-1){1'b1}}};
  localparam logic [AVG_W-1:0] AVG_MIN = {1'b1, {(AVG_W-1){1'b0}}};

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_COMMIT = 5'b00010,
    ST_LOAD   = 5'b00100,
    ST_DIV    = 5'b01000,
    ST_OUT    = 5'b10000
  } wma_state_e;

  typedef struct packed {
    logic start;   // latch sample, read oldest entry
    logic commit;  // write entry, update sum/count/pointer
  } wma_ring_ctl_t;

endpackage

// File: rtl/wma_serdiv.sv
`timescale 1ns / 1ps
`include "windowed_moving_average_assert.svh"

// Restoring divider, one quotient bit per cycle.
module wma_serdiv #(
  parameter int unsigned NUM_W = 36,
  parameter int unsigned DEN_W = 11
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int unsigned CNT_BW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  nq_q, nq_d;
  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [DEN_W-1:0]  den_q, den_d;
  logic [CNT_BW-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DEN_W:0]    shifted;
  logic [DEN_W:0]    diff;
  logic              ge;

  always_comb begin
    shifted = {rem_q, nq_q[NUM_W-1]};
    ge      = (shifted >= {1'b0, den_q});
    diff    = shifted - {1'b0, den_q};
  end

  always_comb begin
    nq_d   = nq_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      nq_d   = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CNT_BW'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      nq_d  = {nq_q[NUM_W-2:0], ge};
      rem_d = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      cnt_d = cnt_q - CNT_BW'(1);
      if (cnt_q == CNT_BW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nq_q  <= nq_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = nq_q;

  `WMA_ASSERT_NEXT(a_start_busy, start_i, busy_q, "divider not busy after start")
  `WMA_ASSERT_NOW(a_den_nonzero, busy_q, den_q != '0, "divider running on zero divisor")

endmodule

// File: rtl/wma_ring.sv
`timescale 1ns / 1ps
`include "windowed_moving_average_assert.svh"

// Sample ring, running sum, fill count and oldest-entry pointer.
module wma_ring
  import wma_pkg::*;
#(
  parameter int unsigned MAX_WINDOW = 1024,
  parameter int unsigned CNT_W      = 11,
  parameter int unsigned PTR_W      = 10,
  parameter int unsigned SUM_W      = 28
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       clear_i,
  input  logic [CNT_W-1:0]           win_i,
  input  wma_ring_ctl_t              ctl_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  output logic signed [SUM_W-1:0]    sum_o,
  output logic [CNT_W-1:0]           fill_o
);

  logic signed [SAMPLE_W-1:0] mem [MAX_WINDOW];
  logic signed [SAMPLE_W-1:0] rd_q;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic signed [SUM_W-1:0]    sum_q, sum_d;
  logic [CNT_W-1:0]           fill_q, fill_d;
  logic [PTR_W-1:0]           ptr_q, ptr_d;
  logic [PTR_W-1:0]           wr_addr;
  logic [CNT_W-1:0]           ptr_next;
  logic                       full;

  always_comb begin
    full     = (fill_q >= win_i);
    ptr_next = CNT_W'(ptr_q) + CNT_W'(1);
    wr_addr  = full ? ptr_q : fill_q[PTR_W-1:0];
    sum_d    = sum_q;
    fill_d   = fill_q;
    ptr_d    = ptr_q;
    if (clear_i) begin
      sum_d  = '0;
      fill_d = '0;
      ptr_d  = '0;
    end else if (ctl_i.commit) begin
      if (full) begin
        sum_d = sum_q - SUM_W'(rd_q) + SUM_W'(sample_q);
        ptr_d = (ptr_next == win_i) ? '0 : ptr_next[PTR_W-1:0];
      end else begin
        sum_d  = sum_q + SUM_W'(sample_q);
        fill_d = fill_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      fill_q <= '0;
      ptr_q  <= '0;
    end else begin
      sum_q  <= sum_d;
      fill_q <= fill_d;
      ptr_q  <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      sample_q <= sample_i;
      rd_q     <= mem[ptr_q];
    end
    if (ctl_i.commit) begin
      mem[wr_addr] <= sample_q;
    end
  end

  assign sum_o  = sum_q;
  assign fill_o = fill_q;

  `WMA_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= win_i, "fill count beyond window")
  `WMA_ASSERT_NOW(a_ptr_bound, fill_q != '0, CNT_W'(ptr_q) < win_i, "ring pointer beyond window")

endmodule

// File: rtl/windowed_moving_average.sv
`timescale 1ns / 1ps
`include "windowed_moving_average_assert.svh"

// Simple moving average over the last window_size signed samples. Each
// accepted word yields one result word: the mean of the held samples in
// signed Q.FRACTION_BITS, truncated toward zero, plus the count held. One
// word at a time is processed, through a bit-serial divider that yields
// one quotient bit per clock. A new word is taken while a result still
// waits on the output. Writing cfg_wdata_i sets the window size (0 acts
// as 1, values above MAX_WINDOW saturate) and clears the window; write
// only while idle.
module windowed_moving_average
  import wma_pkg::*;
#(
  parameter int unsigned MAX_WINDOW    = 1024,
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [WSIZE_W-1:0]     cfg_wdata_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [17:0] sample
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [25:0] average_q8, [36:26] samples_held
);

  localparam int unsigned CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int unsigned PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned SUM_W = SAMPLE_W + $clog2(MAX_WINDOW);
  localparam int unsigned NUM_W = SUM_W + FRACTION_BITS;
  localparam int unsigned CMP_W = (NUM_W > AVG_W) ? NUM_W : AVG_W;

  wma_state_e              state_q, state_d;
  logic [WSIZE_W-1:0]      wsize_q;
  logic [CNT_W-1:0]        win;
  wma_ring_ctl_t           ring_ctl;
  logic signed [SUM_W-1:0] sum;
  logic [CNT_W-1:0]        fill;
  logic [SUM_W-1:0]        mag;
  logic                    div_start;
  logic                    div_busy;
  logic                    div_done;
  logic [NUM_W-1:0]        quot;
  logic [CMP_W-1:0]        quot_x;
  logic                    neg_q;
  logic [HELD_W-1:0]       held_q;
  logic [AVG_W-1:0]        avg;
  logic                    out_valid_q;
  logic                    out_load;
  logic [AVG_W-1:0]        out_avg_q;
  logic [HELD_W-1:0]       out_held_q;

  always_comb begin
    if (wsize_q == '0) begin
      win = CNT_W'(1);
    end else if (32'(wsize_q) > MAX_WINDOW) begin
      win = CNT_W'(MAX_WINDOW);
    end else begin
      win = CNT_W'(wsize_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wsize_q <= WSIZE_RESET;
    end else if (cfg_we_i) begin
      wsize_q <= cfg_wdata_i;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign out_load      = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);
  assign div_start     = (state_q == ST_LOAD);

  always_comb begin
    ring_ctl.start  = s_axis_tvalid && s_axis_tready;
    ring_ctl.commit = (state_q == ST_COMMIT);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (s_axis_tvalid) state_d = ST_COMMIT;
      ST_COMMIT: state_d = ST_LOAD;
      ST_LOAD:   state_d = ST_DIV;
      ST_DIV:    if (div_done) state_d = ST_OUT;
      ST_OUT:    if (out_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  wma_ring #(
    .MAX_WINDOW (MAX_WINDOW),
    .CNT_W      (CNT_W),
    .PTR_W      (PTR_W),
    .SUM_W      (SUM_W)
  ) u_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clear_i  (cfg_we_i),
    .win_i    (win),
    .ctl_i    (ring_ctl),
    .sample_i (s_axis_tdata[SAMPLE_W-1:0]),
    .sum_o    (sum),
    .fill_o   (fill)
  );

  assign mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

  wma_serdiv #(
    .NUM_W (NUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (NUM_W'(mag) << FRACTION_BITS),
    .den_i   (fill),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      neg_q  <= sum[SUM_W-1];
      held_q <= HELD_W'(fill);
    end
  end

  // Restore sign, clamp to the output range.
  always_comb begin
    quot_x = CMP_W'(quot);
    if (neg_q) begin
      avg = (quot_x > CMP_W'(AVG_MIN)) ? AVG_MIN : AVG_W'(-quot_x[AVG_W-1:0]);
    end else begin
      avg = (quot_x > CMP_W'(AVG_MAX)) ? AVG_MAX : quot_x[AVG_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_avg_q  <= avg;
      out_held_q <= held_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_TDATA_W - AVG_W - HELD_W)'(0), out_held_q, out_avg_q};

  `WMA_ASSERT_NOW(a_done_in_div, div_done, state_q == ST_DIV, "divider finished outside divide state")
  `WMA_ASSERT_NOW(a_div_busy_state, div_busy, state_q == ST_DIV, "divider running outside divide state")

endmodule
